// File: hdl/cdut_pkg.sv
// Shared types and constants for the civil date / epoch seconds converter.
// Holds the request and response word layouts, calendar constants and
// small lookup functions. No dependencies.
package cdut_pkg;

   typedef enum logic {
      CMD_DATE_TO_SECS = 1'b0,
      CMD_SECS_TO_DATE = 1'b1
   } cmd_type;

   typedef struct packed {
      logic        command;
      logic [11:0] year_in;
      logic [3:0]  month_in;
      logic [5:0]  day_in;
      logic [4:0]  hour_in;
      logic [5:0]  minute_in;
      logic [5:0]  second_in;
      logic [32:0] seconds_in;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [31:0] seconds_out;
      logic [11:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
   } rsp_type;

   // Clamp limits
   localparam logic [11:0] YEAR_LOW     = 12'd1970;
   localparam logic [11:0] YEAR_HIGH    = 12'd2099;
   localparam logic [3:0]  MONTH_HIGH   = 4'd12;
   localparam logic [4:0]  DAY_HIGH     = 5'd31;
   localparam logic [4:0]  HOUR_HIGH    = 5'd23;
   localparam logic [5:0]  MINSEC_HIGH  = 6'd59;

   // Only eras 4 and 5 are reachable for the supported ranges
   localparam logic [11:0] ERA4_YEAR    = 12'd1600;
   localparam logic [11:0] ERA5_YEAR    = 12'd2000;
   localparam logic [19:0] DAYS_PER_ERA = 20'd146097;
   localparam logic [19:0] ERA4_DAYS    = 20'(4 * DAYS_PER_ERA);
   localparam logic [19:0] ERA5_DAYS    = 20'(5 * DAYS_PER_ERA);
   localparam logic [19:0] EPOCH_SHIFT  = 20'd719468;

   localparam logic [17:0] DAYS_PER_YEAR = 18'd365;
   localparam logic [17:0] DAYS_PER_CENT = 18'd36524;
   localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [11:0] SECS_PER_MIN  = 12'd60;

   // Seconds per day split as 128 * 675
   localparam int unsigned SECS_DAY_SHIFT = 7;
   localparam logic [25:0] SECS_DAY_ODD   = 26'd675;

   // Reciprocals: ceil(2^k / d) with k = width(x) + width(d), exact floor
   localparam logic [26:0] RCP_675  = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
   localparam logic [18:0] RCP_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
   localparam logic [17:0] RCP_3600 = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
   localparam logic [18:0] RCP_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
   localparam logic [12:0] RCP_60   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
   localparam logic [11:0] RCP_153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

   // First day of year (March based) for month index 0..11
   function automatic logic [8:0] month_start(input logic [3:0] mi);
      logic [8:0] res;
      unique case (mi)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd61;
         4'd3:    res = 9'd92;
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd184;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd245;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd337;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

   // Year of era divided by 100, year of era below 400
   function automatic logic [1:0] yoe_div100(input logic [8:0] yoe);
      logic [1:0] res;
      priority if (yoe >= 9'd300) res = 2'd3;
      else if (yoe >= 9'd200)     res = 2'd2;
      else if (yoe >= 9'd100)     res = 2'd1;
      else                        res = 2'd0;
      return res;
   endfunction

endpackage

// File: hdl/civil_date_unix_time_convert_core.sv
// Civil date / Unix epoch seconds converter, eight-stage pipeline.
// Depends on cdut_pkg for word layouts, constants and lookup functions.
//
// Takes one request word per clock unless a held output has filled the pipeline, and
// returns one response word per request, in order. The stage count is set by the
// seconds-to-date path: the divisions by 86400, 1460, 365, 3600, 60 and 153 are constant
// reciprocal multiplies, each followed by a register, and they chain through the stages.
// Every stage has its own valid bit and moves whenever the stage after it is empty or
// moving, so bubbles close up while rsp_ready is low and req_ready stays high until the
// pipeline is full. No state is kept between words.
module civil_date_unix_time_convert_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdut_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdut_pkg::rsp_type rsp_word
);

   typedef struct packed {
      logic        cmd;
      logic        ok;
      logic        f_era5;
      logic [8:0]  f_yoe;
      logic [3:0]  f_mi;
      logic [4:0]  f_day;
      logic [4:0]  f_hour;
      logic [5:0]  f_min;
      logic [5:0]  f_sec;
      logic [25:0] b_q1;
      logic [6:0]  b_r1;
      logic [16:0] b_days;
   } s1_type;

   typedef struct packed {
      logic        cmd;
      logic        ok;
      logic [16:0] f_days;
      logic [16:0] f_hms;
      logic [16:0] b_rem;
      logic        b_era5;
      logic [17:0] b_doe;
   } s2_type;

   typedef struct packed {
      logic        cmd;
      logic        ok;
      logic [31:0] f_secs;
      logic [17:0] b_doe;
      logic        b_era5;
      logic [16:0] b_rem;
      logic [6:0]  b_c1460;
      logic [2:0]  b_c36524;
      logic        b_c146096;
      logic [4:0]  b_hh;
   } s3_type;

   typedef struct packed {
      logic        cmd;
      logic        ok;
      logic [31:0] f_secs;
      logic [17:0] b_doe;
      logic        b_era5;
      logic [17:0] b_ynum;
      logic [11:0] b_rm;
      logic [4:0]  b_hh;
   } s4_type;

   typedef struct packed {
      logic        cmd;
      logic        ok;
      logic [31:0] f_secs;
      logic [17:0] b_doe;
      logic        b_era5;
      logic [8:0]  b_yoe;
      logic [11:0] b_rm;
      logic [5:0]  b_mn;
      logic [4:0]  b_hh;
   } s5_type;

   typedef struct packed {
      logic        cmd;
      logic        ok;
      logic [31:0] f_secs;
      logic [8:0]  b_doy;
      logic [11:0] b_yy;
      logic [4:0]  b_hh;
      logic [5:0]  b_mn;
      logic [5:0]  b_ss;
   } s6_type;

   typedef struct packed {
      logic        cmd;
      logic        ok;
      logic [31:0] f_secs;
      logic [8:0]  b_doy;
      logic [11:0] b_yy;
      logic [3:0]  b_mp;
      logic [4:0]  b_hh;
      logic [5:0]  b_mn;
      logic [5:0]  b_ss;
   } s7_type;

   // Stage control
   logic [6:0] vld_ff;
   logic [6:0] vld_in;
   logic [7:0] stage_en;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   s6_type s6_in, s6_ff;
   s7_type s7_in, s7_ff;
   cdut_pkg::rsp_type rsp_in, rsp_ff;

   // Stage 1 temporaries
   logic [11:0] yr_clamp;
   logic [3:0]  mon_clamp;
   logic [11:0] yr_shift;
   logic        yr_era5;
   logic [52:0] prod_675;
   // Stage 2 temporaries
   logic [17:0] f_doe;
   logic [19:0] f_days_wide;
   logic [25:0] b_day_secs;
   logic [25:0] b_rem_wide;
   logic [19:0] b_z;
   logic        b_z_era5;
   logic [19:0] b_doe_wide;
   // Stage 3 temporaries
   logic [33:0] f_secs_wide;
   logic [36:0] prod_1460;
   logic [34:0] prod_3600;
   // Stage 4 temporaries
   logic [16:0] b_rm_wide;
   // Stage 5 temporaries
   logic [36:0] prod_365;
   logic [24:0] prod_60;
   // Stage 6 temporaries
   logic [17:0] b_year_start;
   logic [17:0] b_doy_wide;
   logic [11:0] b_ss_wide;
   // Stage 7 temporaries
   logic [10:0] b_mp_num;
   logic [22:0] prod_153;
   // Output temporaries
   logic [8:0]  o_day_wide;
   logic [3:0]  o_month;
   logic [11:0] o_year;

   // Each stage loads when it is empty or its content moves on
   always_comb begin
      stage_en[7] = !rsp_valid_ff || rsp_ready;
      for (int k = 6; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
   end

   assign req_ready = stage_en[0];

   always_comb begin
      vld_in = vld_ff;
      if (stage_en[0]) vld_in[0] = req_valid;
      for (int k = 1; k < 7; k++) begin
         if (stage_en[k]) vld_in[k] = vld_ff[k-1];
      end
      rsp_valid_in = stage_en[7] ? vld_ff[6] : rsp_valid_ff;
   end

   // Stage 1: validate and clamp the date, compute the day count of the timestamp
   always_comb begin
      yr_clamp = (req_word.year_in < cdut_pkg::YEAR_LOW) ? cdut_pkg::YEAR_LOW :
                 (req_word.year_in > cdut_pkg::YEAR_HIGH) ? cdut_pkg::YEAR_HIGH :
                 req_word.year_in;
      mon_clamp = (req_word.month_in > cdut_pkg::MONTH_HIGH) ? cdut_pkg::MONTH_HIGH :
                  req_word.month_in;
      yr_shift = yr_clamp - ((mon_clamp <= 4'd2) ? 12'd1 : 12'd0);
      yr_era5  = (yr_shift >= cdut_pkg::ERA5_YEAR);
      prod_675 = 53'(req_word.seconds_in[32:cdut_pkg::SECS_DAY_SHIFT]) *
                 53'(cdut_pkg::RCP_675);

      s1_in.cmd = req_word.command;
      if (req_word.command == cdut_pkg::CMD_SECS_TO_DATE) begin
         s1_in.ok = (req_word.seconds_in != 33'd0);
      end else begin
         s1_in.ok = (req_word.year_in != 12'd0) && (req_word.month_in != 4'd0) &&
                    (req_word.day_in != 6'd0);
      end
      s1_in.f_era5 = yr_era5;
      s1_in.f_yoe  = 9'(yr_shift - (yr_era5 ? cdut_pkg::ERA5_YEAR : cdut_pkg::ERA4_YEAR));
      s1_in.f_mi   = (mon_clamp > 4'd2) ? (mon_clamp - 4'd3) : (mon_clamp + 4'd9);
      s1_in.f_day  = (req_word.day_in > 6'(cdut_pkg::DAY_HIGH)) ? cdut_pkg::DAY_HIGH :
                     req_word.day_in[4:0];
      s1_in.f_hour = (req_word.hour_in > cdut_pkg::HOUR_HIGH) ? cdut_pkg::HOUR_HIGH :
                     req_word.hour_in;
      s1_in.f_min  = (req_word.minute_in > cdut_pkg::MINSEC_HIGH) ? cdut_pkg::MINSEC_HIGH :
                     req_word.minute_in;
      s1_in.f_sec  = (req_word.second_in > cdut_pkg::MINSEC_HIGH) ? cdut_pkg::MINSEC_HIGH :
                     req_word.second_in;
      s1_in.b_q1   = req_word.seconds_in[32:cdut_pkg::SECS_DAY_SHIFT];
      s1_in.b_r1   = req_word.seconds_in[cdut_pkg::SECS_DAY_SHIFT-1:0];
      s1_in.b_days = prod_675[52:36];
   end

   // Stage 2: day count of the date; seconds of day and day of era of the timestamp
   always_comb begin
      f_doe = s1_ff.f_yoe * cdut_pkg::DAYS_PER_YEAR + 18'(s1_ff.f_yoe >> 2)
              - 18'(cdut_pkg::yoe_div100(s1_ff.f_yoe))
              + 18'(cdut_pkg::month_start(s1_ff.f_mi)) + 18'(s1_ff.f_day) - 18'd1;
      f_days_wide = (s1_ff.f_era5 ? cdut_pkg::ERA5_DAYS : cdut_pkg::ERA4_DAYS)
                    + 20'(f_doe) - cdut_pkg::EPOCH_SHIFT;
      b_day_secs = 26'(s1_ff.b_days) * cdut_pkg::SECS_DAY_ODD;
      b_rem_wide = s1_ff.b_q1 - b_day_secs;
      b_z        = 20'(s1_ff.b_days) + cdut_pkg::EPOCH_SHIFT;
      b_z_era5   = (b_z >= cdut_pkg::ERA5_DAYS);
      b_doe_wide = b_z - (b_z_era5 ? cdut_pkg::ERA5_DAYS : cdut_pkg::ERA4_DAYS);

      s2_in.cmd    = s1_ff.cmd;
      s2_in.ok     = s1_ff.ok;
      s2_in.f_days = f_days_wide[16:0];
      s2_in.f_hms  = 17'(s1_ff.f_hour) * cdut_pkg::SECS_PER_HOUR
                     + 17'(s1_ff.f_min) * 17'(cdut_pkg::SECS_PER_MIN) + 17'(s1_ff.f_sec);
      s2_in.b_rem  = {b_rem_wide[9:0], s1_ff.b_r1};
      s2_in.b_era5 = b_z_era5;
      s2_in.b_doe  = b_doe_wide[17:0];
   end

   // Stage 3: epoch seconds of the date; leap corrections and hour of the timestamp
   always_comb begin
      f_secs_wide = 34'(s2_ff.f_days) * 34'(cdut_pkg::SECS_PER_DAY) + 34'(s2_ff.f_hms);
      prod_1460   = 37'(s2_ff.b_doe) * 37'(cdut_pkg::RCP_1460);
      prod_3600   = 35'(s2_ff.b_rem) * 35'(cdut_pkg::RCP_3600);

      s3_in.cmd     = s2_ff.cmd;
      s3_in.ok      = s2_ff.ok;
      s3_in.f_secs  = f_secs_wide[31:0];
      s3_in.b_doe   = s2_ff.b_doe;
      s3_in.b_era5  = s2_ff.b_era5;
      s3_in.b_rem   = s2_ff.b_rem;
      s3_in.b_c1460 = prod_1460[35:29];
      priority if (s2_ff.b_doe >= 18'(4 * cdut_pkg::DAYS_PER_CENT)) s3_in.b_c36524 = 3'd4;
      else if (s2_ff.b_doe >= 18'(3 * cdut_pkg::DAYS_PER_CENT))     s3_in.b_c36524 = 3'd3;
      else if (s2_ff.b_doe >= 18'(2 * cdut_pkg::DAYS_PER_CENT))     s3_in.b_c36524 = 3'd2;
      else if (s2_ff.b_doe >= cdut_pkg::DAYS_PER_CENT)               s3_in.b_c36524 = 3'd1;
      else                                                           s3_in.b_c36524 = 3'd0;
      s3_in.b_c146096 = (s2_ff.b_doe == cdut_pkg::ERA_LAST_DAY);
      s3_in.b_hh      = prod_3600[33:29];
   end

   // Stage 4: leap-free day count; seconds within the hour
   always_comb begin
      b_rm_wide = s3_ff.b_rem - 17'(s3_ff.b_hh) * cdut_pkg::SECS_PER_HOUR;

      s4_in.cmd    = s3_ff.cmd;
      s4_in.ok     = s3_ff.ok;
      s4_in.f_secs = s3_ff.f_secs;
      s4_in.b_doe  = s3_ff.b_doe;
      s4_in.b_era5 = s3_ff.b_era5;
      s4_in.b_ynum = s3_ff.b_doe - 18'(s3_ff.b_c1460) + 18'(s3_ff.b_c36524)
                     - 18'(s3_ff.b_c146096);
      s4_in.b_rm   = b_rm_wide[11:0];
      s4_in.b_hh   = s3_ff.b_hh;
   end

   // Stage 5: year of era; minute
   always_comb begin
      prod_365 = 37'(s4_ff.b_ynum) * 37'(cdut_pkg::RCP_365);
      prod_60  = 25'(s4_ff.b_rm) * 25'(cdut_pkg::RCP_60);

      s5_in.cmd    = s4_ff.cmd;
      s5_in.ok     = s4_ff.ok;
      s5_in.f_secs = s4_ff.f_secs;
      s5_in.b_doe  = s4_ff.b_doe;
      s5_in.b_era5 = s4_ff.b_era5;
      s5_in.b_yoe  = prod_365[35:27];
      s5_in.b_rm   = s4_ff.b_rm;
      s5_in.b_mn   = prod_60[23:18];
      s5_in.b_hh   = s4_ff.b_hh;
   end

   // Stage 6: day of year, March-based year; second
   always_comb begin
      b_year_start = s5_ff.b_yoe * cdut_pkg::DAYS_PER_YEAR + 18'(s5_ff.b_yoe >> 2)
                     - 18'(cdut_pkg::yoe_div100(s5_ff.b_yoe));
      b_doy_wide   = s5_ff.b_doe - b_year_start;
      b_ss_wide    = s5_ff.b_rm - 12'(s5_ff.b_mn) * cdut_pkg::SECS_PER_MIN;

      s6_in.cmd    = s5_ff.cmd;
      s6_in.ok     = s5_ff.ok;
      s6_in.f_secs = s5_ff.f_secs;
      s6_in.b_doy  = b_doy_wide[8:0];
      s6_in.b_yy   = 12'(s5_ff.b_yoe)
                     + (s5_ff.b_era5 ? cdut_pkg::ERA5_YEAR : cdut_pkg::ERA4_YEAR);
      s6_in.b_hh   = s5_ff.b_hh;
      s6_in.b_mn   = s5_ff.b_mn;
      s6_in.b_ss   = b_ss_wide[5:0];
   end

   // Stage 7: month index from day of year
   always_comb begin
      b_mp_num = 11'(s6_ff.b_doy) * 11'd5 + 11'd2;
      prod_153 = 23'(b_mp_num) * 23'(cdut_pkg::RCP_153);

      s7_in.cmd    = s6_ff.cmd;
      s7_in.ok     = s6_ff.ok;
      s7_in.f_secs = s6_ff.f_secs;
      s7_in.b_doy  = s6_ff.b_doy;
      s7_in.b_yy   = s6_ff.b_yy;
      s7_in.b_mp   = prod_153[22:19];
      s7_in.b_hh   = s6_ff.b_hh;
      s7_in.b_mn   = s6_ff.b_mn;
      s7_in.b_ss   = s6_ff.b_ss;
   end

   // Output: day and calendar month, January and February fall in the next year
   always_comb begin
      o_day_wide = s7_ff.b_doy - cdut_pkg::month_start(s7_ff.b_mp) + 9'd1;
      o_month    = (s7_ff.b_mp < 4'd10) ? (s7_ff.b_mp + 4'd3) : (s7_ff.b_mp - 4'd9);
      o_year     = s7_ff.b_yy + ((o_month <= 4'd2) ? 12'd1 : 12'd0);

      rsp_in           = '0;
      rsp_in.valid_res = s7_ff.ok;
      if (s7_ff.ok) begin
         if (s7_ff.cmd == cdut_pkg::CMD_SECS_TO_DATE) begin
            rsp_in.year_out   = o_year;
            rsp_in.month_out  = o_month;
            rsp_in.day_out    = o_day_wide[4:0];
            rsp_in.hour_out   = s7_ff.b_hh;
            rsp_in.minute_out = s7_ff.b_mn;
            rsp_in.second_out = s7_ff.b_ss;
         end else begin
            rsp_in.seconds_out = s7_ff.f_secs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: advance each stage only when its enable is up
   always_ff @(posedge clock) begin
      if (stage_en[0]) s1_ff  <= s1_in;
      if (stage_en[1]) s2_ff  <= s2_in;
      if (stage_en[2]) s3_ff  <= s3_in;
      if (stage_en[3]) s4_ff  <= s4_in;
      if (stage_en[4]) s5_ff  <= s5_in;
      if (stage_en[5]) s6_ff  <= s6_in;
      if (stage_en[6]) s7_ff  <= s7_in;
      if (stage_en[7]) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // A held output word must not block an empty first stage
   a_bubble_accept: assert property (@(posedge clock) disable iff (reset)
      (!vld_ff[0]) |-> req_ready)
      else $error("first stage empty but request not taken");

   // Date fields of a delivered word stay in calendar range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.month_out != 4'd0) |->
      (rsp_word.month_out <= 4'd12 && rsp_word.day_out != 5'd0 &&
       rsp_word.hour_out <= 5'd23 && rsp_word.minute_out <= 6'd59 &&
       rsp_word.second_out <= 6'd59 && rsp_word.year_out >= 12'd1970))
      else $error("date field out of range");

   // Seconds and date results never appear in the same word
   a_result_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.seconds_out != 32'd0) |->
      (rsp_word.year_out == 12'd0 && rsp_word.month_out == 4'd0 && rsp_word.valid_res))
      else $error("seconds and date both present");

   // A full pipeline under output stall takes nothing new
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && (&vld_ff)) |-> !req_ready)
      else $error("request taken while pipeline full and stalled");

endmodule
